// ===== design/spq_pkg.sv =====
package spq_pkg;

   // Default sizes of the queue
   localparam int QueueDepth    = 16;
   localparam int DataWidth     = 32;
   localparam int PriorityWidth = 8;

   // Operation codes of a request item
   typedef enum logic [1:0] {
      OP_ENQ   = 2'd0,
      OP_DEQ   = 2'd1,
      OP_FRONT = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   // Shift command broadcast to every cell of the chain
   typedef struct packed {
      logic enq;
      logic deq;
   } cell_ctrl_type;

endpackage

// ===== design/spq_intf.sv =====
interface spq_req_if #(
   parameter int DATA_WIDTH     = spq_pkg::DataWidth,
   parameter int PRIORITY_WIDTH = spq_pkg::PriorityWidth
);
   logic                      valid;
   logic                      ready;
   logic [1:0]                opcode;
   logic [DATA_WIDTH-1:0]     data_in;
   logic [PRIORITY_WIDTH-1:0] prio;

   modport source (output valid, opcode, data_in, prio, input ready);
   modport sink (input valid, opcode, data_in, prio, output ready);
endinterface

interface spq_rsp_if #(
   parameter int DATA_WIDTH = spq_pkg::DataWidth
);
   logic                  valid;
   logic                  ready;
   logic                  ok;
   logic [DATA_WIDTH-1:0] data_out;
   logic                  empty_flag;
   logic                  full_flag;

   modport source (output valid, ok, data_out, empty_flag, full_flag, input ready);
   modport sink (input valid, ok, data_out, empty_flag, full_flag, output ready);
endinterface

// ===== design/spq_cell.sv =====
module spq_cell #(
   parameter int DATA_WIDTH     = spq_pkg::DataWidth,
   parameter int PRIORITY_WIDTH = spq_pkg::PriorityWidth
) (
   input  logic                      clock,
   input  logic                      reset,
   input  spq_pkg::cell_ctrl_type    ctrl,
   input  logic [DATA_WIDTH-1:0]     new_value,
   input  logic [PRIORITY_WIDTH-1:0] new_prio,
   input  logic                      left_keep,
   input  logic [DATA_WIDTH-1:0]     left_value,
   input  logic [PRIORITY_WIDTH-1:0] left_prio,
   input  logic                      left_valid,
   input  logic [DATA_WIDTH-1:0]     right_value,
   input  logic [PRIORITY_WIDTH-1:0] right_prio,
   input  logic                      right_valid,
   output logic [DATA_WIDTH-1:0]     value,
   output logic [PRIORITY_WIDTH-1:0] prio,
   output logic                      valid,
   output logic                      keep
);
   import spq_pkg::*;

   logic [DATA_WIDTH-1:0]     value_ff, value_in;
   logic [PRIORITY_WIDTH-1:0] prio_ff, prio_in;
   logic                      valid_ff, valid_in;

   // Stay in place when this entry ranks at or above the new element
   assign keep = valid_ff && (prio_ff >= new_prio);

   // Pick the next content: hold, take the new element, or shift
   always_comb begin
      value_in = value_ff;
      prio_in  = prio_ff;
      valid_in = valid_ff;
      priority if (ctrl.enq) begin
         if (!keep) begin
            if (left_keep) begin
               value_in = new_value;
               prio_in  = new_prio;
               valid_in = 1'b1;
            end else begin
               value_in = left_value;
               prio_in  = left_prio;
               valid_in = left_valid;
            end
         end
      end else if (ctrl.deq) begin
         value_in = right_value;
         prio_in  = right_prio;
         valid_in = right_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
         prio_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         value_ff <= value_in;
         prio_ff  <= prio_in;
         valid_ff <= valid_in;
      end
   end

   assign value = value_ff;
   assign prio  = prio_ff;
   assign valid = valid_ff;

endmodule

// ===== design/stable_priority_queue_unit.sv =====
// Stable bounded priority queue built as a sorted chain of cells.
// Request channel req_ch carries opcode, data_in and prio; opcode 0 enqueues,
// 1 dequeues the head, 2 reads the head without removing it, 3 does nothing.
// Response channel rsp_ch returns one item per request: ok, data_out (head
// value on a successful dequeue or front, zero otherwise), and empty_flag and
// full_flag describing the queue after the operation.
// Equal priorities leave in arrival order; enqueue on a full queue and
// dequeue or front on an empty queue return ok low and change nothing.
// Response: the item is valid in the cycle after the request is taken.
// Throughput: one item per cycle while the receiver takes each response; every
// cell compares its priority with the incoming one and shifts in the same cycle,
// so the chain update is a single step regardless of QUEUE_DEPTH.
// Stall: the response sits in an output register; while it waits, a new
// request is taken only in the cycle the receiver takes the held response.
// Reset: synchronous, active high; every cell is cleared and the queue is
// empty, the response register holds no item.
module stable_priority_queue_unit #(
   parameter int QUEUE_DEPTH    = spq_pkg::QueueDepth,
   parameter int DATA_WIDTH     = spq_pkg::DataWidth,
   parameter int PRIORITY_WIDTH = spq_pkg::PriorityWidth
) (
   input logic      clock,
   input logic      reset,
   spq_req_if.sink   req_ch,
   spq_rsp_if.source rsp_ch
);
   import spq_pkg::*;

   logic [DATA_WIDTH-1:0]     cell_value [QUEUE_DEPTH];
   logic [PRIORITY_WIDTH-1:0] cell_prio  [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0]    cell_valid;
   logic [QUEUE_DEPTH-1:0]    cell_keep;

   logic          req_fire;
   logic          is_enq, is_deq, is_front;
   logic          q_empty, q_full;
   logic          enq_ok, deq_ok, front_ok;
   cell_ctrl_type ctrl;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_ok_ff, rsp_ok_in;
   logic [DATA_WIDTH-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_empty_ff, rsp_empty_in;
   logic                  rsp_full_ff, rsp_full_in;

   // Take a request when the response register is free or being drained
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_fire     = req_ch.valid && req_ch.ready;

   // Decode the operation and check it against occupancy
   assign is_enq   = (req_ch.opcode == OP_ENQ);
   assign is_deq   = (req_ch.opcode == OP_DEQ);
   assign is_front = (req_ch.opcode == OP_FRONT);
   assign q_empty  = !cell_valid[0];
   assign q_full   = cell_valid[QUEUE_DEPTH-1];
   assign enq_ok   = req_fire && is_enq && !q_full;
   assign deq_ok   = req_fire && is_deq && !q_empty;
   assign front_ok = req_fire && is_front && !q_empty;

   assign ctrl.enq = enq_ok;
   assign ctrl.deq = deq_ok;

   // Chain of cells, head at index zero
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic                      l_keep;
      logic [DATA_WIDTH-1:0]     l_value, r_value;
      logic [PRIORITY_WIDTH-1:0] l_prio, r_prio;
      logic                      l_valid, r_valid;

      if (i == 0) begin : g_head
         assign l_keep  = 1'b1;
         assign l_value = '0;
         assign l_prio  = '0;
         assign l_valid = 1'b0;
      end else begin : g_body
         assign l_keep  = cell_keep[i-1];
         assign l_value = cell_value[i-1];
         assign l_prio  = cell_prio[i-1];
         assign l_valid = cell_valid[i-1];
      end

      if (i == QUEUE_DEPTH-1) begin : g_tail
         assign r_value = '0;
         assign r_prio  = '0;
         assign r_valid = 1'b0;
      end else begin : g_link
         assign r_value = cell_value[i+1];
         assign r_prio  = cell_prio[i+1];
         assign r_valid = cell_valid[i+1];
      end

      spq_cell #(
         .DATA_WIDTH     (DATA_WIDTH),
         .PRIORITY_WIDTH (PRIORITY_WIDTH)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .new_value   (req_ch.data_in),
         .new_prio    (req_ch.prio),
         .left_keep   (l_keep),
         .left_value  (l_value),
         .left_prio   (l_prio),
         .left_valid  (l_valid),
         .right_value (r_value),
         .right_prio  (r_prio),
         .right_valid (r_valid),
         .value       (cell_value[i]),
         .prio        (cell_prio[i]),
         .valid       (cell_valid[i]),
         .keep        (cell_keep[i])
      );
   end

   // Build the response from the head and the occupancy after the update
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_full_in  = rsp_full_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = enq_ok || deq_ok || front_ok;
         rsp_data_in  = (deq_ok || front_ok) ? cell_value[0] : '0;
         priority if (enq_ok) begin
            rsp_empty_in = 1'b0;
            rsp_full_in  = cell_valid[QUEUE_DEPTH-2];
         end else if (deq_ok) begin
            rsp_empty_in = !cell_valid[1];
            rsp_full_in  = 1'b0;
         end else begin
            rsp_empty_in = q_empty;
            rsp_full_in  = q_full;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ok_ff    <= rsp_ok_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_full_ff  <= rsp_full_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.ok         = rsp_ok_ff;
   assign rsp_ch.data_out   = rsp_data_ff;
   assign rsp_ch.empty_flag = rsp_empty_ff;
   assign rsp_ch.full_flag  = rsp_full_ff;

`ifndef SYNTHESIS
   // Valid cells always form a prefix starting at the head
   a_valid_prefix: assert property (@(posedge clock) disable iff (reset)
      (cell_valid & (cell_valid + 1'b1)) == '0)
      else $error("valid cells do not form a prefix");

   // An enqueue into a queue with room succeeds and leaves it non-empty
   a_enq_ok: assert property (@(posedge clock) disable iff (reset)
      (req_fire && is_enq && !q_full) |=> (rsp_ok_ff && !rsp_empty_ff && cell_valid[0]))
      else $error("enqueue with room did not succeed");

   // A successful dequeue frees the tail cell
   a_deq_frees: assert property (@(posedge clock) disable iff (reset)
      (req_fire && is_deq && !q_empty) |=> !cell_valid[QUEUE_DEPTH-1])
      else $error("dequeue did not free the tail cell");

   // Reported flags match the chain while the response is fresh
   a_flags_match: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (rsp_empty_ff == !cell_valid[0])
                   && (rsp_full_ff == cell_valid[QUEUE_DEPTH-1]))
      else $error("response flags disagree with the chain");
`endif

endmodule

// ===== tb/sv/tb_stable_priority_queue_unit.sv =====
module tb_stable_priority_queue_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import spq_pkg::*;

   // Fixed priority pattern used to fill the queue in the directed part
   localparam logic [PriorityWidth-1:0] FILL_PRIO [16] = '{
      8'd0, 8'd255, 8'd255, 8'd128, 8'd0, 8'd1, 8'd254, 8'd128,
      8'd7, 8'd7, 8'd7, 8'd200, 8'd3, 8'd255, 8'd0, 8'd64
   };
   localparam int LONG_HOLD_CYCLES = 60;

   // One response item as the queue should return it
   typedef struct packed {
      logic                 ok;
      logic [DataWidth-1:0] data;
      logic                 empty;
      logic                 full;
   } reply_item_type;

   // Shadow copy of the sorted cell chain plus the replies still owed
   class queue_tracker;
      logic [DataWidth-1:0]     slot_value [QueueDepth];
      logic [PriorityWidth-1:0] slot_prio  [QueueDepth];
      int                       fill;
      reply_item_type           awaited [$];
      int                       mismatches;

      function new();
         fill = 0;
         mismatches = 0;
         foreach (slot_value[i]) begin
            slot_value[i] = '0;
            slot_prio[i]  = '0;
         end
      endfunction

      // Apply one accepted request to the shadow chain and queue its reply
      function void note_request(opcode_type op, logic [DataWidth-1:0] value,
                                 logic [PriorityWidth-1:0] prio);
         reply_item_type r;
         int pos;
         int i;
         r.ok   = 1'b0;
         r.data = '0;
         case (op)
            OP_ENQ: begin
               if (fill < QueueDepth) begin
                  // land behind every entry of greater or equal priority
                  pos = 0;
                  while (pos < fill && slot_prio[pos] >= prio) pos++;
                  for (i = fill; i > pos; i--) begin
                     slot_value[i] = slot_value[i-1];
                     slot_prio[i]  = slot_prio[i-1];
                  end
                  slot_value[pos] = value;
                  slot_prio[pos]  = prio;
                  fill++;
                  r.ok = 1'b1;
               end
            end
            OP_DEQ: begin
               if (fill > 0) begin
                  r.data = slot_value[0];
                  for (i = 0; i < QueueDepth - 1; i++) begin
                     slot_value[i] = slot_value[i+1];
                     slot_prio[i]  = slot_prio[i+1];
                  end
                  slot_value[QueueDepth-1] = '0;
                  slot_prio[QueueDepth-1]  = '0;
                  fill--;
                  r.ok = 1'b1;
               end
            end
            OP_FRONT: begin
               if (fill > 0) begin
                  r.data = slot_value[0];
                  r.ok   = 1'b1;
               end
            end
            default: begin
            end
         endcase
         r.empty = (fill == 0);
         r.full  = (fill == QueueDepth);
         awaited.push_back(r);
      endfunction

      // Compare a returned item against the oldest reply owed
      function void check_reply(reply_item_type got);
         reply_item_type want;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: response with nothing pending: %s",
                        $realtime,
                        $sformatf("ok=%0b data=%h empty=%0b full=%0b",
                                  got.ok, got.data, got.empty, got.full));
         end else begin
            want = awaited.pop_front();
            if (got.ok !== want.ok || got.data !== want.data ||
                got.empty !== want.empty || got.full !== want.full) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: expected %s, got %s",
                           $realtime,
                           $sformatf("ok=%0b data=%h empty=%0b full=%0b",
                                     want.ok, want.data, want.empty, want.full),
                           $sformatf("ok=%0b data=%h empty=%0b full=%0b",
                                     got.ok, got.data, got.empty, got.full));
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int   send_idle_pct;
   int   recv_idle_pct;
   logic long_hold_req;
   logic long_hold_done;

   queue_tracker tracker = new();

   spq_req_if req_if ();
   spq_rsp_if rsp_if ();

   stable_priority_queue_unit u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   // Free-running clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard stop in case the handshake hangs
   initial begin
      #5ms;
      $display("stable_priority_queue_unit: mismatch");
      $finish;
   end

   // Sample both channels mid-cycle, where all values for the next edge are settled
   always @(negedge clock) begin : monitor
      reply_item_type seen;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            seen.ok    = rsp_if.ok;
            seen.data  = rsp_if.data_out;
            seen.empty = rsp_if.empty_flag;
            seen.full  = rsp_if.full_flag;
            tracker.check_reply(seen);
         end
         if (req_if.valid && req_if.ready)
            tracker.note_request(opcode_type'(req_if.opcode), req_if.data_in, req_if.prio);
      end
   end

   // Drive response ready; one long hold-off when asked, counted here
   initial begin : receiver
      int held;
      rsp_if.ready   <= 1'b0;
      long_hold_done <= 1'b0;
      @(posedge clock);
      forever begin
         if (reset) begin
            rsp_if.ready <= 1'b0;
         end else if (long_hold_req && !long_hold_done) begin
            rsp_if.ready <= 1'b0;
            for (held = 0; held < LONG_HOLD_CYCLES; held++) @(posedge clock);
            long_hold_done <= 1'b1;
            rsp_if.ready   <= 1'b1;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
         @(posedge clock);
      end
   end

   // Offer one item, idling first at random, and return once it is taken
   task automatic send_item(opcode_type op, logic [DataWidth-1:0] value,
                            logic [PriorityWidth-1:0] prio);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.opcode  <= op;
      req_if.data_in <= value;
      req_if.prio    <= prio;
      @(negedge clock);
      while (!req_if.ready) @(negedge clock);
      @(posedge clock);
   endtask

   // Random item; enq_pct steers the queue toward full or empty
   task automatic send_random(int enq_pct);
      opcode_type               op;
      logic [PriorityWidth-1:0] prio;
      int                       r;
      r = $urandom_range(99);
      if (r < 4) begin
         op = OP_NONE;
      end else begin
         r = $urandom_range(99);
         if (r < enq_pct) op = OP_ENQ;
         else if (r < enq_pct + (100 - enq_pct) * 3 / 4) op = OP_DEQ;
         else op = OP_FRONT;
      end
      // crowd priorities into a few values often, so ties are common
      case ($urandom_range(3))
         0: prio = PriorityWidth'($urandom_range(3));
         1: prio = $urandom_range(1) ? '1 : '0;
         default: prio = PriorityWidth'($urandom_range(255));
      endcase
      send_item(op, DataWidth'($urandom), prio);
   endtask

   initial begin : stimulus
      int k;
      int phase;
      int enq_pct;
      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.opcode  <= OP_NONE;
      req_if.data_in <= '0;
      req_if.prio    <= '0;
      long_hold_req  <= 1'b0;
      send_idle_pct  <= 19;
      recv_idle_pct  <= 74;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Empty queue: front, dequeue and no-op all fail
      send_item(OP_FRONT, '0, '0);
      send_item(OP_DEQ, '1, '1);
      send_item(OP_NONE, '1, '1);
      // Fill to capacity with extreme values and tied priorities
      for (k = 0; k < QueueDepth; k++)
         send_item(OP_ENQ, (k == 0) ? '0 : (k == 1) ? '1 : DataWidth'($urandom),
                   FILL_PRIO[k % 16]);
      // Full queue: enqueue is rejected, no-op reports full, front reads the head, two dequeues follow
      send_item(OP_ENQ, DataWidth'($urandom), '1);
      send_item(OP_NONE, DataWidth'($urandom), PriorityWidth'($urandom));
      send_item(OP_FRONT, DataWidth'($urandom), PriorityWidth'($urandom));
      send_item(OP_DEQ, DataWidth'($urandom), PriorityWidth'($urandom));
      send_item(OP_DEQ, DataWidth'($urandom), PriorityWidth'($urandom));

      // Random part: three idling profiles, long receiver hold in the last
      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct <= 19;
               recv_idle_pct <= 74;
            end
            1: begin
               send_idle_pct <= 74;
               recv_idle_pct <= 19;
            end
            default: begin
               send_idle_pct <= 0;
               recv_idle_pct <= 0;
               long_hold_req <= 1'b1;
            end
         endcase
         enq_pct = 50;
         for (k = 0; k < 526; k++) begin
            if (k % 35 == 0) begin
               case ($urandom_range(3))
                  0: enq_pct = 15;
                  1: enq_pct = 50;
                  2: enq_pct = 80;
                  default: enq_pct = 95;
               endcase
            end
            send_random(enq_pct);
         end
      end
      req_if.valid <= 1'b0;

      // Drain outstanding replies, then let any stray responses show before the verdict
      while (tracker.awaited.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (tracker.mismatches == 0 && tracker.awaited.size() == 0) begin
         $display("stable_priority_queue_unit: match");
      end else begin
         $display("stable_priority_queue_unit: mismatch");
      end
      $finish;
   end

endmodule
